// File: hdl/tss_pkg.sv
// shared types and constants for the timed step sequencer
`default_nettype none

package tss_pkg;

    localparam int MAX_STEPS    = 16;
    localparam int IDX_W        = $clog2(MAX_STEPS);
    localparam int CNT_W        = $clog2(MAX_STEPS + 1);
    localparam int LENGTH_W     = 16;
    localparam int KIND_W       = 2;
    localparam int ELAPSED_W    = 17;
    localparam int STEP_FIELD_W = 4;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 8;

    localparam logic [KIND_W-1:0] KIND_TIMED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAITING = 2'd1;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_APPEND = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SKIP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [3:0]          pad;
        logic                condition_met;
        logic                run_only_after_timeout;
        logic [LENGTH_W-1:0] step_length;
        logic [KIND_W-1:0]   step_kind;
    } in_word_t;

    typedef struct packed {
        logic                    table_full;
        logic                    ended_by_timeout;
        logic                    active;
        logic [STEP_FIELD_W-1:0] current_step;
        logic                    step_started;
    } out_word_t;

    typedef struct packed {
        logic [LENGTH_W-1:0] length;
        logic [KIND_W-1:0]   kind;
    } step_word_t;

    typedef struct packed {
        logic start;
        logic eval;
        logic skip;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_append;
        logic tick_eval;
        logic tick_start;
        logic eval_done;
        logic eval_more;
        logic skip_more;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/tss_ctrl.sv
// controller state machine of the timed step sequencer
`default_nettype none

module tss_ctrl
    import tss_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (status.is_append)
                        state_next = S_DONE;
                    else if (status.tick_eval)
                        state_next = S_EVAL;
                    else if (status.tick_start)
                        state_next = S_SKIP;
                    else
                        state_next = S_DONE;
                end
            end
            S_EVAL:
            begin
                if (status.eval_done && status.eval_more)
                    state_next = S_SKIP;
                else
                    state_next = S_DONE;
            end
            S_SKIP:
            begin
                if (!status.skip_more)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            S_SKIP:
            begin
                cmd.skip = 1'b1;
            end
            S_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// File: hdl/tss_datapath.sv
// step table, timing and result datapath of the timed step sequencer
`default_nettype none

module tss_datapath
    import tss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STEPS);

    in_word_t              in_word;
    step_word_t            step_mem [MAX_STEPS];
    step_word_t            rd_data_reg;
    logic [MAX_STEPS-1:0]  cond_reg;
    logic [MAX_STEPS-1:0]  marks_reg;
    logic [MAX_STEPS-1:0]  marks_next;
    logic [CNT_W-1:0]      loaded_count_reg;
    logic [CNT_W-1:0]      loaded_count_next;
    logic [CNT_W-1:0]      next_index_reg;
    logic [CNT_W-1:0]      next_index_next;
    logic [ELAPSED_W-1:0]  elapsed_reg;
    logic [ELAPSED_W-1:0]  elapsed_next;
    logic                  running_reg;
    logic                  running_next;
    logic                  started_reg;
    logic                  started_next;
    logic                  ended_reg;
    logic                  ended_next;
    logic                  full_reg;
    logic                  full_next;
    logic                  cond_met_reg;
    logic                  m_tvalid_reg;
    out_word_t             out_word_reg;
    out_word_t             out_word_next;

    logic [IDX_W-1:0]      cur_idx;
    logic [IDX_W-1:0]      walk_idx;
    logic [IDX_W-1:0]      prev_idx;
    logic [IDX_W-1:0]      load_idx;
    logic [CNT_W-1:0]      step_pos;
    logic [ELAPSED_W-1:0]  elapsed_inc;
    logic                  over;
    logic                  eval_done;
    logic                  eval_to;
    logic                  walk_in_range;
    logic                  walk_blocked;
    logic                  do_append;
    logic                  room;

    assign in_word   = in_word_t'(s_tdata);
    assign cur_idx   = IDX_W'(next_index_reg - 1'b1);
    assign walk_idx  = next_index_reg[IDX_W-1:0];
    assign prev_idx  = walk_idx - 1'b1;
    assign load_idx  = loaded_count_reg[IDX_W-1:0];
    assign room      = loaded_count_reg < MAX_CNT;
    assign do_append = cmd.start && (s_tuser == CMD_APPEND);

    // saturating tick count and end-of-step decision
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign over = elapsed_inc > {{(ELAPSED_W-LENGTH_W){1'b0}}, rd_data_reg.length};

    always_comb
    begin
        eval_done = 1'b0;
        eval_to   = 1'b0;
        case (rd_data_reg.kind)
            KIND_TIMED:
            begin
                eval_done = over;
                eval_to   = over;
            end
            KIND_WAITING:
            begin
                eval_done = cond_met_reg;
            end
            default:
            begin
                eval_done = over || cond_met_reg;
                eval_to   = over;
            end
        endcase
    end

    // conditional steps are skipped unless their predecessor timed out or was itself skipped
    assign walk_in_range = next_index_reg < loaded_count_reg;
    assign walk_blocked  = cond_reg[walk_idx]
                           && !((walk_idx != '0) && marks_reg[prev_idx]);

    assign status.is_append  = s_tuser == CMD_APPEND;
    assign status.tick_eval  = running_reg && (next_index_reg != '0)
                               && (next_index_reg <= loaded_count_reg);
    assign status.tick_start = !running_reg && walk_in_range;
    assign status.eval_done  = eval_done;
    assign status.eval_more  = walk_in_range;
    assign status.skip_more  = walk_in_range && walk_blocked;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign step_pos = (next_index_reg != '0) ? next_index_reg - 1'b1 : '0;

    always_comb
    begin
        marks_next        = marks_reg;
        loaded_count_next = loaded_count_reg;
        next_index_next   = next_index_reg;
        elapsed_next      = elapsed_reg;
        running_next      = running_reg;
        started_next      = started_reg;
        ended_next        = ended_reg;
        full_next         = full_reg;

        if (cmd.start)
        begin
            started_next = 1'b0;
            ended_next   = 1'b0;
            full_next    = 1'b0;
            if (do_append)
            begin
                if (room)
                begin
                    marks_next[load_idx] = 1'b0;
                    loaded_count_next    = loaded_count_reg + 1'b1;
                end
                else
                begin
                    full_next = 1'b1;
                end
            end
        end

        if (cmd.eval)
        begin
            elapsed_next = elapsed_inc;
            if (eval_done)
            begin
                marks_next[cur_idx] = eval_to;
                ended_next          = eval_to;
                if (!walk_in_range)
                    running_next = 1'b0;
            end
        end

        if (cmd.skip)
        begin
            if (walk_in_range && walk_blocked)
            begin
                marks_next[walk_idx] = 1'b1;
                next_index_next      = next_index_reg + 1'b1;
            end
            else if (walk_in_range)
            begin
                next_index_next = next_index_reg + 1'b1;
                elapsed_next    = '0;
                running_next    = 1'b1;
                started_next    = 1'b1;
            end
            else
            begin
                running_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_word_next                  = out_word_reg;
        if (cmd.load_out)
        begin
            out_word_next.step_started     = started_reg;
            out_word_next.current_step     = STEP_FIELD_W'(step_pos);
            out_word_next.active           = running_reg;
            out_word_next.ended_by_timeout = ended_reg;
            out_word_next.table_full       = full_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_append && room)
        begin
            step_mem[load_idx] <= '{length: in_word.step_length, kind: in_word.step_kind};
            cond_reg[load_idx] <= in_word.run_only_after_timeout;
        end
        if (cmd.start)
        begin
            rd_data_reg  <= step_mem[cur_idx];
            cond_met_reg <= in_word.condition_met;
        end
    end

    always_ff @(posedge clk)
    begin
        started_reg  <= started_next;
        ended_reg    <= ended_next;
        full_reg     <= full_next;
        elapsed_reg  <= elapsed_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg        <= '0;
            loaded_count_reg <= '0;
            next_index_reg   <= '0;
            running_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            marks_reg        <= marks_next;
            loaded_count_reg <= loaded_count_next;
            next_index_reg   <= next_index_next;
            running_reg      <= running_next;
            if (cmd.load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_word_reg;

    a_running_index: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (next_index_reg != '0) && (next_index_reg <= loaded_count_reg))
        else $error("running with step index outside loaded steps");

    a_skip_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.skip && walk_in_range) |=> next_index_reg == $past(next_index_reg) + 1'b1)
        else $error("skip walk did not advance the step index");

    a_eval_keeps_running: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval && !eval_done) |=> running_reg)
        else $error("unfinished step stopped running");

    a_full_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        (do_append && !room) |=> loaded_count_reg == $past(loaded_count_reg))
        else $error("append into full table changed the step count");

endmodule

`default_nettype wire

// File: hdl/timed_step_sequencer_core.sv
// top level of the timed step sequencer
`default_nettype none

// Timed step sequencer. Append words (tuser 1) add a step to a table of
// MAX_STEPS entries; tick words (tuser 0) advance time by one tick and carry
// the done condition of the step in progress. Every input word yields exactly
// one result word. An append goes from acceptance straight to the result state;
// a tick first evaluates the running step, if any, and when that step has ended
// or none runs and more steps are loaded, walks the step table to start the next
// one, one entry per cycle; this skip walk sets the worst case. The next word is
// taken once the current one has been moved into the output register, even while
// that result still waits for m_tready. No clearing pass is needed after reset.
module timed_step_sequencer_core
    import tss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // step_kind[1:0], step_length[17:2], run_only_after_timeout[18],
    // condition_met[19], zero[23:20]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // cmd[0]
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // step_started[0], current_step[4:1], active[5], ended_by_timeout[6],
    // table_full[7]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tss_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// File: test/timed_step_sequencer_core_test.sv
// testbench for the timed step sequencer core: directed and random words checked against a predictor
`timescale 1ns / 1ps

module timed_step_sequencer_core_test;
    import tss_pkg::*;

    localparam logic [KIND_W-1:0] KIND_WAIT_TO = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ODD     = 2'd3;
    localparam int ELAPSED_SAT  = 131071;
    localparam int RANDOM_WORDS = 1100;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    bit calm;
    bit hold_req;
    int errors;
    int stall_cycles;

    // sequencer shadow state
    logic [KIND_W-1:0]   plan_kind [MAX_STEPS];
    logic [LENGTH_W-1:0] plan_len  [MAX_STEPS];
    logic                plan_cond [MAX_STEPS];
    logic                timed_out [MAX_STEPS];
    int                  steps_loaded;
    int                  next_step;
    int                  elapsed;
    logic                seq_running;

    out_word_t due_results [$];

    timed_step_sequencer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // skip conditional steps whose predecessor neither timed out nor was itself skipped
    function automatic logic begin_next_step();
        int idx;
        idx = next_step;
        while (idx < steps_loaded && plan_cond[idx] && !(idx > 0 && timed_out[idx - 1]))
        begin
            timed_out[idx] = 1'b1;
            idx++;
        end
        if (idx < steps_loaded)
        begin
            next_step   = idx + 1;
            elapsed     = 0;
            seq_running = 1'b1;
            return 1'b1;
        end
        next_step   = idx;
        seq_running = 1'b0;
        return 1'b0;
    endfunction

    function automatic out_word_t advance_sequencer(input logic cmd, input in_word_t w);
        out_word_t r;
        int        cur;
        logic      over;
        logic      done;
        logic      to;
        r = '0;
        if (cmd == CMD_APPEND)
        begin
            if (steps_loaded >= MAX_STEPS)
                r.table_full = 1'b1;
            else
            begin
                plan_kind[steps_loaded] = w.step_kind;
                plan_len[steps_loaded]  = w.step_length;
                plan_cond[steps_loaded] = w.run_only_after_timeout;
                timed_out[steps_loaded] = 1'b0;
                steps_loaded++;
            end
        end
        else if (seq_running && next_step > 0 && next_step <= steps_loaded)
        begin
            cur = next_step - 1;
            if (elapsed < ELAPSED_SAT)
                elapsed++;
            over = elapsed > plan_len[cur];
            done = 1'b0;
            to   = 1'b0;
            case (plan_kind[cur])
                KIND_TIMED:
                begin
                    done = over;
                    to   = over;
                end
                KIND_WAITING:
                    done = w.condition_met;
                default:
                begin
                    done = over | w.condition_met;
                    to   = over;
                end
            endcase
            if (done)
            begin
                timed_out[cur]     = to;
                r.ended_by_timeout = to;
                if (next_step < steps_loaded)
                    r.step_started = begin_next_step();
                else
                    seq_running = 1'b0;
            end
        end
        else if (!seq_running && next_step < steps_loaded)
            r.step_started = begin_next_step();
        r.current_step = STEP_FIELD_W'((next_step > 0) ? next_step - 1 : 0);
        r.active       = seq_running;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s mismatch: got %0d, want %0d", name, got, want));
    endtask

    task automatic send_word(input logic cmd, input logic [KIND_W-1:0] kind,
                             input logic [LENGTH_W-1:0] len, input logic cflag,
                             input logic cmet);
        in_word_t w;
        w                        = '0;
        w.step_kind              = kind;
        w.step_length            = len;
        w.run_only_after_timeout = cflag;
        w.condition_met          = cmet;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due_results.push_back(advance_sequencer(cmd, w));
        @(negedge clk);
    endtask

    task automatic append_step(input logic [KIND_W-1:0] kind, input logic [LENGTH_W-1:0] len,
                               input logic cflag);
        send_word(CMD_APPEND, kind, len, cflag, 1'($urandom_range(0, 1)));
    endtask

    // step fields of a tick word are ignored, so they carry noise
    task automatic tick(input logic cmet);
        send_word(CMD_TICK, KIND_W'($urandom_range(0, 3)), LENGTH_W'($urandom),
                  1'($urandom_range(0, 1)), cmet);
    endtask

    task automatic append_random_step();
        logic [LENGTH_W-1:0] len;
        len = LENGTH_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                     : $urandom_range(0, 12));
        append_step(KIND_W'($urandom_range(0, 3)), len, $urandom_range(0, 2) == 0);
    endtask

    task automatic test_empty_table();
        send_word(CMD_TICK, KIND_TIMED, 16'h0000, 1'b0, 1'b0);
        send_word(CMD_TICK, KIND_ODD, 16'hffff, 1'b1, 1'b1);
    endtask

    task automatic test_step_kinds();
        // first step conditional, so it is skipped
        append_step(KIND_ODD, 16'hffff, 1'b1);
        append_step(KIND_TIMED, 16'd0, 1'b0);
        tick(1'b0);
        tick(1'b1);
        // conditional step after a timeout runs, ends on its condition
        append_step(KIND_WAIT_TO, 16'd1, 1'b1);
        append_step(KIND_WAITING, 16'hffff, 1'b0);
        tick(1'b0);
        tick(1'b1);
        // appends while a step runs
        append_step(KIND_WAIT_TO, 16'd2, 1'b1);
        append_step(KIND_TIMED, 16'd3, 1'b1);
        tick(1'b0);
        tick(1'b0);
        tick(1'b1);
        repeat (4) tick(1'($urandom_range(0, 1)));
        // timeout and condition on the same tick
        append_step(KIND_ODD, 16'd2, 1'b0);
        tick(1'b0);
        tick(1'b0);
        tick(1'b0);
        tick(1'b1);
        // skip walk runs off the end of the loaded steps
        append_step(KIND_WAITING, 16'd0, 1'b0);
        append_step(KIND_TIMED, 16'd7, 1'b1);
        tick(1'b0);
        tick(1'b1);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (24) tick($urandom_range(0, 4) == 0);
    endtask

    task automatic test_random_steps();
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (steps_loaded < MAX_STEPS && $urandom_range(0, 119) == 0)
                append_random_step();
            else
                tick($urandom_range(0, 4) == 0);
        end
    endtask

    task automatic test_full_table();
        calm = 1'b1;
        while (steps_loaded < MAX_STEPS)
            append_random_step();
        append_step(KIND_ODD, 16'hffff, 1'b1);
        append_step(KIND_TIMED, 16'd0, 1'b0);
        repeat (80) tick($urandom_range(0, 4) == 0);
        append_step(KIND_WAITING, 16'h5a5a, 1'b1);
    endtask

    // result sink: random stalls, one long hold on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_word_t got;
        out_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = out_word_t'(m_tdata);
            if (due_results.size() == 0)
                report_mismatch($sformatf("result word 0x%02h with nothing pending", m_tdata));
            else
            begin
                want = due_results.pop_front();
                check_field("step_started", got.step_started, want.step_started);
                check_field("current_step", got.current_step, want.current_step);
                check_field("active", got.active, want.active);
                check_field("ended_by_timeout", got.ended_by_timeout, want.ended_by_timeout);
                check_field("table_full", got.table_full, want.table_full);
            end
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        errors       = 0;
        steps_loaded = 0;
        next_step    = 0;
        elapsed      = 0;
        seq_running  = 1'b0;
        for (int i = 0; i < MAX_STEPS; i++)
            timed_out[i] = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_table();
        test_step_kinds();
        test_backpressure();
        test_random_steps();
        test_full_table();

        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
